// ===== hdl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types, constants and command byte table for the SD card SPI-mode
// start-up sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned CmdLen    = 6;
  localparam int unsigned Cmd55Tail = 4;

  localparam logic [7:0] IdleByte    = 8'hFF;
  localparam logic [7:0] R1Idle      = 8'h01;
  localparam logic [7:0] R1Ok        = 8'h00;

  localparam logic [7:0] SyncCountRst = 8'd12;
  localparam logic [4:0] RespWinRst   = 5'd6;
  localparam logic [7:0] AcmdArgRst   = 8'h40;
  localparam logic [7:0] Cmd58ExpRst  = 8'h01;

  typedef enum logic [1:0] {
    CFG_SYNC_COUNT = 2'd0,
    CFG_RESP_WIN   = 2'd1,
    CFG_ACMD_ARG   = 2'd2,
    CFG_CMD58_EXP  = 2'd3
  } cfg_idx_e;

  // one-hot sequencer phase
  typedef enum logic [6:0] {
    PH_SYNC   = 7'b000_0001,
    PH_CMD0   = 7'b000_0010,
    PH_CMD8   = 7'b000_0100,
    PH_CMD55  = 7'b000_1000,
    PH_ACMD41 = 7'b001_0000,
    PH_CMD58  = 7'b010_0000,
    PH_READY  = 7'b100_0000
  } phase_e;

  localparam logic [2:0] PhCodeSync   = 3'd0;
  localparam logic [2:0] PhCodeCmd0   = 3'd1;
  localparam logic [2:0] PhCodeCmd8   = 3'd2;
  localparam logic [2:0] PhCodeCmd55  = 3'd3;
  localparam logic [2:0] PhCodeAcmd41 = 3'd4;
  localparam logic [2:0] PhCodeCmd58  = 3'd5;
  localparam logic [2:0] PhCodeReady  = 3'd6;

  typedef struct packed {
    logic       card_ready;
    logic [2:0] init_phase;
    logic       chip_select_high;
    logic [7:0] tx_byte;
  } result_t;

  function automatic logic [2:0] phase_code(input phase_e ph);
    logic [2:0] code;
    unique case (ph)
      PH_SYNC:   code = PhCodeSync;
      PH_CMD0:   code = PhCodeCmd0;
      PH_CMD8:   code = PhCodeCmd8;
      PH_CMD55:  code = PhCodeCmd55;
      PH_ACMD41: code = PhCodeAcmd41;
      PH_CMD58:  code = PhCodeCmd58;
      default:   code = PhCodeReady;
    endcase
    return code;
  endfunction

  // command frame bytes, position 0..5
  function automatic logic [7:0] cmd_byte(input phase_e ph, input logic [2:0] pos,
                                          input logic [7:0] acmd_arg);
    logic [7:0] b;
    b = 8'h00;
    unique case (ph)
      PH_CMD0: begin
        if (pos == 3'd0) b = 8'h40;
        else if (pos == 3'd5) b = 8'h95;
      end
      PH_CMD8: begin
        if (pos == 3'd0) b = 8'h48;
        else if (pos == 3'd3) b = 8'h01;
        else if (pos == 3'd4) b = 8'hAA;
        else if (pos == 3'd5) b = 8'h87;
      end
      PH_CMD55: begin
        if (pos == 3'd0) b = 8'h77;
        else if (pos == 3'd5) b = 8'h01;
      end
      PH_ACMD41: begin
        if (pos == 3'd0) b = 8'h69;
        else if (pos == 3'd1) b = acmd_arg;
        else if (pos == 3'd5) b = 8'h01;
      end
      PH_CMD58: begin
        if (pos == 3'd0) b = 8'h7A;
        else if (pos == 3'd5) b = 8'h01;
      end
      default: b = IdleByte;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/sd_spi_init_sequencer.sv =====
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer
// SD card SPI-mode start-up sequencer, one byte exchange per stream item.
// ----------------------------------------------------------------------------
// Each input item is a start (tuser 0) or a completed byte exchange (tuser 1,
// received byte in tdata); each produces exactly one result with the next
// byte to send, chip-select level, phase code and ready flag. The block takes
// one item per clock: the state update and the result are computed
// combinationally and land in a two-entry output buffer, so input is stalled
// only when both entries hold results the sink has not taken. Configuration
// writes are always accepted (cfg_ready_o tied high) and take effect at once.
module sd_spi_init_sequencer
  import sdspi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] tx_byte, [8] chip_select_high,
                                      // [11:9] init_phase, [12] card_ready
);

  logic [7:0] sync_cnt_q;
  logic [4:0] resp_win_q;
  logic [7:0] acmd_arg_q;
  logic [7:0] cmd58_exp_q;

  phase_e     phase_q, phase_d;
  logic [7:0] pos_q, pos_d;
  logic       matched_q, matched_d;

  result_t    head_q, skid_q, res_d;
  logic       head_vld_q, skid_vld_q;

  logic       in_xfer, out_xfer;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~skid_vld_q;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign out_xfer      = head_vld_q & m_axis_tready;
  assign m_axis_tvalid = head_vld_q;
  assign m_axis_tdata  = {3'b000, head_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_cnt_q  <= SyncCountRst;
      resp_win_q  <= RespWinRst;
      acmd_arg_q  <= AcmdArgRst;
      cmd58_exp_q <= Cmd58ExpRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SYNC_COUNT: sync_cnt_q  <= cfg_data_i;
        CFG_RESP_WIN:   resp_win_q  <= cfg_data_i[4:0];
        CFG_ACMD_ARG:   acmd_arg_q  <= cfg_data_i;
        CFG_CMD58_EXP:  cmd58_exp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next sequencer state
  logic [8:0] pos_inc;
  logic [7:0] sync_lim;
  logic [4:0] win;
  logic [5:0] cmd_lim;
  logic [7:0] wanted;
  logic       cmd_phase;
  logic       hit;

  always_comb begin
    pos_inc   = {1'b0, pos_q} + 9'd1;
    sync_lim  = (sync_cnt_q == 8'd0) ? 8'd1 : sync_cnt_q;
    win       = (resp_win_q == 5'd0) ? 5'd1 : resp_win_q;
    cmd_lim   = 6'(CmdLen) + {1'b0, win};
    cmd_phase = (phase_q == PH_CMD0) || (phase_q == PH_CMD8) ||
                (phase_q == PH_ACMD41) || (phase_q == PH_CMD58);
    wanted    = (phase_q == PH_ACMD41) ? R1Ok :
                (phase_q == PH_CMD58) ? cmd58_exp_q : R1Idle;
    hit       = (pos_q >= 8'(CmdLen)) && (s_axis_tdata == wanted);

    phase_d   = phase_q;
    pos_d     = pos_inc[7:0];
    matched_d = matched_q;

    if (!s_axis_tuser) begin
      phase_d   = PH_SYNC;
      pos_d     = 8'd0;
      matched_d = 1'b0;
    end else if (phase_q == PH_SYNC) begin
      if (pos_inc >= {1'b0, sync_lim}) begin
        phase_d = PH_CMD0;
        pos_d   = 8'd0;
      end
    end else if (phase_q == PH_CMD55) begin
      if (pos_inc >= 9'(CmdLen + Cmd55Tail)) begin
        phase_d = PH_ACMD41;
        pos_d   = 8'd0;
      end
    end else if (cmd_phase) begin
      matched_d = matched_q | hit;
      if (pos_inc >= {3'b000, cmd_lim}) begin
        pos_d     = 8'd0;
        matched_d = 1'b0;
        if (matched_q | hit) begin
          unique case (phase_q)
            PH_CMD0:   phase_d = PH_CMD8;
            PH_CMD8:   phase_d = PH_CMD55;
            PH_ACMD41: phase_d = PH_CMD58;
            default:   phase_d = PH_READY;
          endcase
        end else if (phase_q == PH_ACMD41) begin
          phase_d = PH_CMD55;
        end
      end
    end else begin
      phase_d   = PH_READY;
      pos_d     = 8'd0;
      matched_d = 1'b0;
    end

    res_d.tx_byte          = (pos_d < 8'(CmdLen))
                             ? cmd_byte(phase_d, pos_d[2:0], acmd_arg_q) : IdleByte;
    res_d.chip_select_high = (phase_d == PH_SYNC);
    res_d.init_phase       = phase_code(phase_d);
    res_d.card_ready       = (phase_d == PH_READY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SYNC;
      pos_q     <= 8'd0;
      matched_q <= 1'b0;
    end else if (in_xfer) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      matched_q <= matched_d;
    end
  end

  // two-entry result buffer: head drives the port, skid catches a result
  // produced while head is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (out_xfer) begin
          head_vld_q <= 1'b1;
          skid_vld_q <= 1'b0;
        end
      end else if (head_vld_q) begin
        if (in_xfer && !out_xfer) begin
          skid_vld_q <= 1'b1;
        end else if (!in_xfer && out_xfer) begin
          head_vld_q <= 1'b0;
        end
      end else if (in_xfer) begin
        head_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_xfer) head_q <= skid_q;
    end else if (in_xfer) begin
      if (!head_vld_q || out_xfer) head_q <= res_d;
      else                         skid_q <= res_d;
    end
  end

endmodule
